// File: sv/bdq_pkg.sv
// Shared types and constants for the bounded deque with search.
package bdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int RES_LIMIT = 16;
	localparam int PW = 5;
	localparam int VW = 32;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_SEARCH     = 3'd4;
	localparam logic [2:0] KIND_DUMP       = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	typedef struct packed {
		logic take;
		logic walk_next;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic more;
		logic hit;
		logic dump;
	} stat_t;

endpackage

// File: sv/bounded_deque_with_search.sv
// Top level of the bounded deque with search: controller and datapath.
//
// Input channel (in_valid/in_ready) carries one operation per beat: kind and value.
// Output channel (out_valid/out_ready) carries result beats: status, position,
// element and last. Every operation of kinds 0 to 5 yields one result beat, except
// a dump of a non-empty store, which yields one beat per element (at most 16) with
// last set on the final one. Kinds 6 and 7 are taken and yield nothing.
// Pushes and pops give their result in the cycle after acceptance.
// A search or dump reads the element memory through one registered read port, one
// entry per cycle while the receiver keeps up, visiting up to DEPTH entries for a
// search and up to 16 for a dump. One operation is worked on at a time; a new beat
// is taken once the previous operation has finished and the output register is free
// or draining. A stalled receiver holds the current result beat and pauses the walk.
// Reset empties the store (front index and count go to zero); memory contents are
// left as they are and never read before being written.
module bounded_deque_with_search #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    kind,
	input  logic signed [bdq_pkg::VW-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bdq_pkg::PW-1:0]        position,
	output logic signed [bdq_pkg::VW-1:0] element,
	output logic                          last
);

	bdq_pkg::cmd_t  cmd;
	bdq_pkg::stat_t stat;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.kind     (kind),
		.value    (value),
		.status   (status),
		.position (position),
		.element  (element),
		.last     (last)
	);

endmodule

// File: sv/bdq_ctrl.sv
// Controller state machine for the bounded deque with search.
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	output logic              out_valid,
	input  logic              out_ready,
	input  bdq_pkg::stat_t    stat,
	output bdq_pkg::cmd_t     cmd
);

	bdq_pkg::state_t state_q, state_n;
	logic ov_q;
	logic free;
	logic walk_start;
	logic single;
	logic done;

	assign free = !ov_q || out_ready;

	always_comb begin
		cmd = '0;
		walk_start = 1'b0;
		single = 1'b0;
		done = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				in_ready = free;
				cmd.take = in_valid && free;
				walk_start = cmd.take && !stat.empty &&
					(kind == bdq_pkg::KIND_SEARCH || kind == bdq_pkg::KIND_DUMP);
				single = cmd.take && (kind <= bdq_pkg::KIND_DUMP) && !walk_start;
			end
			bdq_pkg::S_WALK: begin
				if (stat.dump) begin
					cmd.emit = free;
					cmd.walk_next = free && stat.more;
					done = free && !stat.more;
				end else begin
					cmd.emit = free && (stat.hit || !stat.more);
					cmd.walk_next = !stat.hit && stat.more;
					done = cmd.emit;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				if (walk_start) state_n = bdq_pkg::S_WALK;
			end
			bdq_pkg::S_WALK: begin
				if (done) state_n = bdq_pkg::S_IDLE;
			end
			default: begin
				state_n = bdq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ov_q <= (ov_q && !out_ready) || single || cmd.emit;
		end
	end

	assign out_valid = ov_q;

endmodule

// File: sv/bdq_dp.sv
// Datapath of the bounded deque: element memory, ring pointers, walk and result registers.
module bdq_dp #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bdq_pkg::cmd_t               cmd,
	output bdq_pkg::stat_t              stat,
	input  logic [2:0]                  kind,
	input  logic signed [bdq_pkg::VW-1:0] value,
	output logic [1:0]                  status,
	output logic [bdq_pkg::PW-1:0]      position,
	output logic signed [bdq_pkg::VW-1:0] element,
	output logic                        last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LIM = (DEPTH < bdq_pkg::RES_LIMIT) ? DEPTH : bdq_pkg::RES_LIMIT;

	logic signed [bdq_pkg::VW-1:0] mem [DEPTH];

	logic [IW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] ptr_q;
	logic [CW-1:0] idx_q;
	logic signed [bdq_pkg::VW-1:0] key_q;
	logic signed [bdq_pkg::VW-1:0] rdata_q;
	logic dump_q;

	logic [IW:0]   back_sum;
	logic [IW-1:0] back_addr;
	logic [IW-1:0] front_dec;
	logic [IW-1:0] front_inc;
	logic [IW-1:0] ptr_inc;
	logic [CW-1:0] lim;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          walk_start;
	logic [1:0]    single_status;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
		return (a == IW'(DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	assign back_sum = {1'b0, front_q} + (IW + 1)'(count_q);
	assign back_addr = (back_sum >= (IW + 1)'(DEPTH)) ?
		IW'(back_sum - (IW + 1)'(DEPTH)) : back_sum[IW-1:0];
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = wrap_inc(front_q);
	assign ptr_inc = wrap_inc(ptr_q);

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CW'(DEPTH));
	assign lim = (dump_q && count_q > CW'(LIM)) ? CW'(LIM) : count_q;
	assign stat.more = (idx_q < lim);
	assign stat.hit = !dump_q && (rdata_q == key_q);
	assign stat.dump = dump_q;

	assign walk_start = cmd.take && !stat.empty &&
		(kind == bdq_pkg::KIND_SEARCH || kind == bdq_pkg::KIND_DUMP);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = back_addr;
		single_status = bdq_pkg::ST_OK;
		unique case (kind)
			bdq_pkg::KIND_PUSH_FRONT: begin
				wr_en = cmd.take && !stat.full;
				wr_addr = front_dec;
				single_status = stat.full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
			end
			bdq_pkg::KIND_PUSH_BACK: begin
				wr_en = cmd.take && !stat.full;
				single_status = stat.full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
			end
			bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK,
			bdq_pkg::KIND_SEARCH, bdq_pkg::KIND_DUMP: begin
				single_status = stat.empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
			end
			default: begin
				single_status = bdq_pkg::ST_OK;
			end
		endcase
	end

	assign rd_en = walk_start || cmd.walk_next;
	assign rd_addr = walk_start ? front_q : ptr_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= value;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			unique case (kind)
				bdq_pkg::KIND_PUSH_FRONT: begin
					if (!stat.full) begin
						front_q <= front_dec;
						count_q <= count_q + 1'b1;
					end
				end
				bdq_pkg::KIND_PUSH_BACK: begin
					if (!stat.full) count_q <= count_q + 1'b1;
				end
				bdq_pkg::KIND_POP_FRONT: begin
					if (!stat.empty) begin
						front_q <= front_inc;
						count_q <= count_q - 1'b1;
					end
				end
				bdq_pkg::KIND_POP_BACK: begin
					if (!stat.empty) count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (walk_start) begin
			ptr_q <= front_inc;
			idx_q <= CW'(1);
			key_q <= value;
			dump_q <= (kind == bdq_pkg::KIND_DUMP);
		end else if (cmd.walk_next) begin
			ptr_q <= ptr_inc;
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.take && !walk_start) begin
			status <= single_status;
			position <= '0;
			element <= '0;
			last <= 1'b1;
		end else if (cmd.emit) begin
			if (dump_q) begin
				status <= bdq_pkg::ST_OK;
				position <= '0;
				element <= rdata_q;
				last <= !stat.more;
			end else if (stat.hit) begin
				status <= bdq_pkg::ST_OK;
				position <= bdq_pkg::PW'(idx_q);
				element <= '0;
				last <= 1'b1;
			end else begin
				status <= bdq_pkg::ST_NOTFOUND;
				position <= '0;
				element <= '0;
				last <= 1'b1;
			end
		end
	end

endmodule

// File: sv/bdq_checker.sv
// Port-level assertions for the bounded deque with search, bound to its top level.
module bdq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [2:0]                    kind,
	input logic signed [bdq_pkg::VW-1:0] value,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    status,
	input logic [bdq_pkg::PW-1:0]        position,
	input logic signed [bdq_pkg::VW-1:0] element,
	input logic                          last
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(value))
		else $error("input beat changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
			&& $stable(element) && $stable(last))
		else $error("result beat changed while stalled");

	a_pos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position != '0 |-> status == bdq_pkg::ST_OK && last && element == '0)
		else $error("position given outside a successful search result");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bdq_pkg::ST_OK |-> last && position == '0 && element == '0)
		else $error("error result not a single final beat");

	a_busy_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("operation taken while result register is blocked");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (.*);
